[rtl/hc_pkg.sv]
`timescale 1ns / 1ps

package hc_pkg;

    // letter alphabet
    localparam int unsigned LETTER_W = 5;
    localparam logic [LETTER_W-1:0] LETTERS = 5'd26;

    typedef logic [LETTER_W-1:0] t_letter;

    // fold a raw 5-bit code (0..31) onto a residue 0..25
    function automatic t_letter red_letter(input t_letter x);
        red_letter = (x >= LETTERS) ? t_letter'(x - LETTERS) : x;
    endfunction

    // additive inverse mod 26 of a residue
    function automatic t_letter neg_letter(input t_letter x);
        neg_letter = (x == '0) ? '0 : t_letter'(LETTERS - x);
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic t_letter inv_letter(input t_letter x);
        case (x)
            5'd1:    inv_letter = 5'd1;
            5'd3:    inv_letter = 5'd9;
            5'd5:    inv_letter = 5'd21;
            5'd7:    inv_letter = 5'd15;
            5'd9:    inv_letter = 5'd3;
            5'd11:   inv_letter = 5'd19;
            5'd15:   inv_letter = 5'd7;
            5'd17:   inv_letter = 5'd23;
            5'd19:   inv_letter = 5'd11;
            5'd21:   inv_letter = 5'd5;
            5'd23:   inv_letter = 5'd17;
            5'd25:   inv_letter = 5'd25;
            default: inv_letter = 5'd0;
        endcase
    endfunction

endpackage

[rtl/hc_mac.sv]
`timescale 1ns / 1ps

// shared multiply-accumulate mod 26: y = (a * b + c) mod 26, operands below 26
module hc_mac (
    input  hc_pkg::t_letter i_a,
    input  hc_pkg::t_letter i_b,
    input  hc_pkg::t_letter i_c,
    output hc_pkg::t_letter o_y
);

    // floor(2^13 / 26); quotient is exact or one short for sums up to 650
    localparam int unsigned RECIP_SHIFT = 13;
    localparam logic [17:0] RECIP = 18'((1 << RECIP_SHIFT) / 26);

    logic [9:0]  w_sum;
    logic [17:0] w_scaled;
    logic [4:0]  w_quot;
    logic [9:0]  w_rem;

    // product plus addend, at most 650
    assign w_sum = 10'(i_a) * 10'(i_b) + 10'(i_c);

    // quotient estimate by reciprocal multiply
    assign w_scaled = 18'(w_sum) * RECIP;
    assign w_quot   = 5'(w_scaled >> RECIP_SHIFT);

    // remainder below 52, one correction
    assign w_rem = w_sum - 10'(w_quot) * 10'(hc_pkg::LETTERS);
    assign o_y   = (w_rem >= 10'(hc_pkg::LETTERS))
                 ? hc_pkg::t_letter'(w_rem - 10'(hc_pkg::LETTERS))
                 : hc_pkg::t_letter'(w_rem);

endmodule

[rtl/hill_cipher_2x2_mod26.sv]
`timescale 1ns / 1ps

// channel   | direction | ports                                   | handshake
// ----------+-----------+-----------------------------------------+------------------------
// command   | in        | i_mode, i_plain_0..3, i_cipher_0..3     | start & !busy
// result    | out       | o_out_0..3, o_status                    | o_strobe, one cycle
// key write | in        | i_cfg_idx, i_cfg_data                   | i_cfg_we
//
// one word at a time through a single mod-26 multiply-accumulate unit
// encrypt: products only; decrypt, key recovery: all steps; singular: stops at lookup
// (two steps determinant, one inverse lookup, four adjugate steps, two steps per output)
// a new word may be started in the cycle the strobe is shown
// synchronous active-low reset restores the identity key; the receiver cannot stall
module hill_cipher_2x2_mod26 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_mode,
    input  hc_pkg::t_letter i_plain_0,
    input  hc_pkg::t_letter i_plain_1,
    input  hc_pkg::t_letter i_plain_2,
    input  hc_pkg::t_letter i_plain_3,
    input  hc_pkg::t_letter i_cipher_0,
    input  hc_pkg::t_letter i_cipher_1,
    input  hc_pkg::t_letter i_cipher_2,
    input  hc_pkg::t_letter i_cipher_3,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  hc_pkg::t_letter i_cfg_data,
    output logic            o_strobe,
    output hc_pkg::t_letter o_out_0,
    output hc_pkg::t_letter o_out_1,
    output hc_pkg::t_letter o_out_2,
    output hc_pkg::t_letter o_out_3,
    output logic            o_status
);

    localparam logic [1:0] MODE_ENC = 2'd0;
    localparam logic [1:0] MODE_DEC = 2'd1;
    localparam logic [1:0] MODE_KEY = 2'd2;

    localparam logic [1:0] KEY_R0C0 = 2'd0;
    localparam logic [1:0] KEY_R0C1 = 2'd1;
    localparam logic [1:0] KEY_R1C0 = 2'd2;
    localparam logic [1:0] KEY_R1C1 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DET,
        S_LKUP,
        S_INV,
        S_MUL
    } t_state;

    t_state          r_state;
    logic [2:0]      r_step;
    logic            r_recover;
    logic            r_strobe;
    logic            r_status;
    hc_pkg::t_letter r_key [4];
    hc_pkg::t_letter r_m   [4];
    hc_pkg::t_letter r_mi  [4];
    hc_pkg::t_letter r_c   [4];
    hc_pkg::t_letter r_x   [2];
    hc_pkg::t_letter r_out [4];
    hc_pkg::t_letter r_acc;
    hc_pkg::t_letter r_di;

    hc_pkg::t_letter w_a;
    hc_pkg::t_letter w_b;
    hc_pkg::t_letter w_c;
    hc_pkg::t_letter w_y;
    logic            w_term;
    logic [1:0]      w_idx;
    logic            w_mul_last;

    hc_pkg::t_letter w_p [4];
    hc_pkg::t_letter w_q [4];

    // incoming letters folded onto residues
    assign w_p[0] = hc_pkg::red_letter(i_plain_0);
    assign w_p[1] = hc_pkg::red_letter(i_plain_1);
    assign w_p[2] = hc_pkg::red_letter(i_plain_2);
    assign w_p[3] = hc_pkg::red_letter(i_plain_3);
    assign w_q[0] = hc_pkg::red_letter(i_cipher_0);
    assign w_q[1] = hc_pkg::red_letter(i_cipher_1);
    assign w_q[2] = hc_pkg::red_letter(i_cipher_2);
    assign w_q[3] = hc_pkg::red_letter(i_cipher_3);

    // product phase: step bit 0 picks the term, upper bits the output
    assign w_term     = r_step[0];
    assign w_idx      = r_step[2:1];
    assign w_mul_last = r_recover ? (r_step == 3'd7) : (r_step == 3'd3);

    // operand selection for the shared unit
    always_comb begin
        w_a = '0;
        w_b = '0;
        w_c = '0;
        case (r_state)
            S_DET: begin
                if (r_step[0]) begin
                    w_a = hc_pkg::neg_letter(r_m[1]);
                    w_b = r_m[2];
                    w_c = r_acc;
                end else begin
                    w_a = r_m[0];
                    w_b = r_m[3];
                end
            end
            S_INV: begin
                w_a = r_di;
                case (r_step[1:0])
                    2'd0:    w_b = r_m[3];
                    2'd1:    w_b = hc_pkg::neg_letter(r_m[1]);
                    2'd2:    w_b = hc_pkg::neg_letter(r_m[2]);
                    default: w_b = r_m[0];
                endcase
            end
            S_MUL: begin
                if (r_recover) begin
                    w_a = r_c[{w_idx[1], w_term}];
                    w_b = r_mi[{w_term, w_idx[0]}];
                end else begin
                    w_a = r_mi[{w_idx[0], w_term}];
                    w_b = r_x[w_term];
                end
                w_c = w_term ? r_acc : '0;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    hc_mac u_mac (
        .i_a (w_a),
        .i_b (w_b),
        .i_c (w_c),
        .o_y (w_y)
    );

    // sequencer, key registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_strobe  <= 1'b0;
            r_key[0]  <= 5'd1;
            r_key[1]  <= 5'd0;
            r_key[2]  <= 5'd0;
            r_key[3]  <= 5'd1;
        end else begin
            r_strobe <= 1'b0;

            // key writes, to be made only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    KEY_R0C0: r_key[0] <= i_cfg_data;
                    KEY_R0C1: r_key[1] <= i_cfg_data;
                    KEY_R1C0: r_key[2] <= i_cfg_data;
                    KEY_R1C1: r_key[3] <= i_cfg_data;
                    default:  r_key[0] <= r_key[0];
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_step    <= '0;
                        r_status  <= 1'b0;
                        r_recover <= (i_mode == MODE_KEY);
                        for (int i = 0; i < 4; i++) begin
                            r_out[i] <= '0;
                        end
                        r_x[0] <= w_p[0];
                        r_x[1] <= w_p[1];
                        case (i_mode)
                            MODE_ENC: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_mi[i] <= hc_pkg::red_letter(r_key[i]);
                                end
                                r_state <= S_MUL;
                            end
                            MODE_DEC: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_m[i] <= hc_pkg::red_letter(r_key[i]);
                                end
                                r_state <= S_DET;
                            end
                            MODE_KEY: begin
                                // column-wise matrices, stored row-major
                                r_m[0] <= w_p[0];
                                r_m[1] <= w_p[2];
                                r_m[2] <= w_p[1];
                                r_m[3] <= w_p[3];
                                r_c[0] <= w_q[0];
                                r_c[1] <= w_q[2];
                                r_c[2] <= w_q[1];
                                r_c[3] <= w_q[3];
                                r_state <= S_DET;
                            end
                            default: begin
                                // undefined mode reports an error at once
                                r_status <= 1'b1;
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DET: begin
                    r_acc  <= w_y;
                    r_step <= r_step + 3'd1;
                    if (r_step[0]) begin
                        r_state <= S_LKUP;
                    end
                end
                S_LKUP: begin
                    r_di   <= hc_pkg::inv_letter(r_acc);
                    r_step <= '0;
                    if (hc_pkg::inv_letter(r_acc) == '0) begin
                        r_status <= 1'b1;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_INV;
                    end
                end
                S_INV: begin
                    r_mi[r_step[1:0]] <= w_y;
                    if (r_step[1:0] == 2'd3) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_MUL: begin
                    r_acc  <= w_y;
                    r_step <= r_step + 3'd1;
                    if (w_term) begin
                        r_out[w_idx] <= w_y;
                    end
                    if (w_mul_last) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out_0  = r_out[0];
    assign o_out_1  = r_out[1];
    assign o_out_2  = r_out[2];
    assign o_out_3  = r_out[3];
    assign o_status = r_status;

endmodule

[tb/tb_hill_cipher_2x2_mod26.sv]
`timescale 1ns / 1ps

module tb_hill_cipher_2x2_mod26;

    typedef hc_pkg::t_letter t_letter;

    localparam int unsigned ALPHA        = 26;
    localparam int unsigned SETTLE_CYCLE = 20;
    localparam int unsigned RAND_PER_KEY = 70;
    localparam int unsigned KEY_PHASES   = 12;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_SINGULAR = 1'b1;

    typedef enum logic [1:0] {MODE_ENC, MODE_DEC, MODE_KEY, MODE_UNDEF} t_mode;
    typedef enum logic [1:0] {REG_K00, REG_K01, REG_K10, REG_K11} t_key_reg;

    // four letters, index 0 in the low bits
    typedef t_letter [3:0] t_quad;

    typedef struct packed {
        t_mode mode;
        t_quad pt;
        t_quad ct;
    } t_word;

    typedef struct packed {
        t_quad lt;
        logic  st;
    } t_res;

    logic    i_clk;
    logic    i_rst_n  = 1'b0;
    logic    start    = 1'b0;
    logic    busy;
    t_word   cur_word = '0;
    logic    cfg_we   = 1'b0;
    logic [1:0] cfg_idx = '0;
    t_letter cfg_data = '0;
    logic    strobe;
    t_letter out_0, out_1, out_2, out_3;
    logic    status;

    t_word       pending_words[$];
    t_res        predicted_results[$];
    t_quad       key_model;
    int unsigned idle_left = 0;
    logic        drain     = 1'b0;
    bit          gaps_on   = 1'b1;
    int          failures  = 0;

    hill_cipher_2x2_mod26 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_mode     (cur_word.mode),
        .i_plain_0  (cur_word.pt[0]),
        .i_plain_1  (cur_word.pt[1]),
        .i_plain_2  (cur_word.pt[2]),
        .i_plain_3  (cur_word.pt[3]),
        .i_cipher_0 (cur_word.ct[0]),
        .i_cipher_1 (cur_word.ct[1]),
        .i_cipher_2 (cur_word.ct[2]),
        .i_cipher_3 (cur_word.ct[3]),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_strobe   (strobe),
        .o_out_0    (out_0),
        .o_out_1    (out_1),
        .o_out_2    (out_2),
        .o_out_3    (out_3),
        .o_status   (status)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic t_letter fold(input int unsigned v);
        return t_letter'(v % ALPHA);
    endfunction

    // a*b + c*d reduced mod 26
    function automatic t_letter dot2(input int unsigned a, b, c, d);
        return fold(a * b + c * d);
    endfunction

    // multiplicative inverse by search, zero where none exists
    function automatic int unsigned recip(input int unsigned d);
        int unsigned x;
        for (x = 1; x < ALPHA; x++)
            if ((d * x) % ALPHA == 1) return x;
        return 0;
    endfunction

    // inverse of row-major 2x2 matrix mod 26, false if singular
    function automatic logic mat_inv(input t_quad m, output t_quad r);
        int unsigned a, b, c, d, di;
        a  = m[0] % ALPHA;
        b  = m[1] % ALPHA;
        c  = m[2] % ALPHA;
        d  = m[3] % ALPHA;
        di = recip((a * d + ALPHA * ALPHA - b * c) % ALPHA);
        r  = '0;
        if (di == 0) return 1'b0;
        r[0] = fold(di * d);
        r[1] = fold(di * (ALPHA - b));
        r[2] = fold(di * (ALPHA - c));
        r[3] = fold(di * a);
        return 1'b1;
    endfunction

    // expected result word for one command under the given key
    function automatic t_res hill_predict(input t_word w, input t_quad key);
        t_quad inv, pm, cm;
        t_res  r;
        r = '0;
        case (w.mode)
            MODE_ENC: begin
                r.lt[0] = dot2(key[0], w.pt[0], key[1], w.pt[1]);
                r.lt[1] = dot2(key[2], w.pt[0], key[3], w.pt[1]);
            end
            MODE_DEC: begin
                if (mat_inv(key, inv)) begin
                    r.lt[0] = dot2(inv[0], w.pt[0], inv[1], w.pt[1]);
                    r.lt[1] = dot2(inv[2], w.pt[0], inv[3], w.pt[1]);
                end else begin
                    r.st = ST_SINGULAR;
                end
            end
            MODE_KEY: begin
                // letters fill the matrices column by column
                pm = {w.pt[3], w.pt[1], w.pt[2], w.pt[0]};
                cm = {w.ct[3], w.ct[1], w.ct[2], w.ct[0]};
                if (mat_inv(pm, inv)) begin
                    r.lt[0] = dot2(cm[0], inv[0], cm[1], inv[2]);
                    r.lt[1] = dot2(cm[0], inv[1], cm[1], inv[3]);
                    r.lt[2] = dot2(cm[2], inv[0], cm[3], inv[2]);
                    r.lt[3] = dot2(cm[2], inv[1], cm[3], inv[3]);
                end else begin
                    r.st = ST_SINGULAR;
                end
            end
            default: r.st = ST_SINGULAR;
        endcase
        return r;
    endfunction

    function automatic t_quad quad(input int unsigned a, b, c, d);
        return {t_letter'(d), t_letter'(c), t_letter'(b), t_letter'(a)};
    endfunction

    function automatic t_word mk(input t_mode m, input t_quad p, input t_quad c);
        t_word w;
        w.mode = m;
        w.pt   = p;
        w.ct   = c;
        return w;
    endfunction

    // mostly proper letters, sometimes the raw codes above 25
    function automatic t_letter rand_letter();
        if ($urandom_range(0, 99) < 85) return t_letter'($urandom_range(0, ALPHA - 1));
        return t_letter'($urandom_range(0, 31));
    endfunction

    function automatic t_quad rand_quad();
        return {rand_letter(), rand_letter(), rand_letter(), rand_letter()};
    endfunction

    function automatic t_word rand_word();
        t_word       w;
        t_quad       scratch;
        int unsigned pick;
        pick   = $urandom_range(0, 99);
        w.mode = (pick < 28) ? MODE_ENC : (pick < 56) ? MODE_DEC :
                 (pick < 92) ? MODE_KEY : MODE_UNDEF;
        w.pt   = rand_quad();
        w.ct   = rand_quad();
        // key recovery mostly from a plaintext block that can be inverted
        if (w.mode == MODE_KEY && $urandom_range(0, 2) != 0)
            while (!mat_inv(w.pt, scratch)) w.pt = rand_quad();
        return w;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // command driver: hold each word until accepted, then idle or pause
    always @(posedge i_clk) begin : drive
        logic go;
        go = 1'b0;
        if (!i_rst_n) begin
            start     <= 1'b0;
            cur_word  <= '0;
            idle_left <= 0;
            drain     <= 1'b0;
        end else begin
            if (start && !busy)
                predicted_results.push_back(hill_predict(cur_word, key_model));
            if (!start || !busy) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                end else if (drain) begin
                    if (predicted_results.size() == 0) drain <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    go = 1'b1;
                    cur_word  <= pending_words.pop_front();
                    idle_left <= pick_gap();
                    drain     <= ($urandom_range(0, 39) == 0);
                end
                start <= go;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        t_res  want;
        t_quad got;
        int    i;
        if (i_rst_n && strobe) begin
            got = {out_3, out_2, out_1, out_0};
            if (predicted_results.size() == 0) begin
                $error("result word with none outstanding: out %h status %b", got, status);
                failures++;
            end else begin
                want = predicted_results.pop_front();
                for (i = 0; i < 4; i++)
                    if (got[i] !== want.lt[i]) begin
                        $error("out_%0d: expected %0d, actual %0d", i, want.lt[i], got[i]);
                        failures++;
                    end
                if (status !== want.st) begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    failures++;
                end
            end
        end
    end

    // wait for the block to go quiet
    task automatic settle();
        while (pending_words.size() != 0 || predicted_results.size() != 0 || start)
            @(posedge i_clk);
        repeat (SETTLE_CYCLE) @(posedge i_clk);
    endtask

    task automatic load_key(input t_quad k);
        int unsigned r;
        for (r = 0; r < 4; r++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= t_key_reg'(r);
            cfg_data <= k[r];
            key_model[r] = k[r];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // stimulus
    initial begin : stim
        t_quad       key_plan [KEY_PHASES];
        t_quad       scratch;
        int unsigned ph, n;

        key_model = quad(1, 0, 0, 1);
        key_plan[0] = quad(3, 3, 2, 5);
        key_plan[1] = quad(0, 0, 0, 0);
        key_plan[2] = quad(25, 25, 25, 25);
        key_plan[3] = quad(31, 31, 31, 31);
        key_plan[4] = quad(25, 0, 0, 25);
        key_plan[5] = quad(2, 4, 1, 2);
        key_plan[6] = quad(13, 0, 0, 1);
        key_plan[7] = quad(26, 27, 28, 31);
        for (ph = 8; ph < KEY_PHASES; ph++) begin
            do key_plan[ph] = rand_quad();
            while (!mat_inv(key_plan[ph], scratch));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset key
        pending_words.push_back(mk(MODE_ENC, quad(0, 0, 0, 0), quad(0, 0, 0, 0)));
        pending_words.push_back(mk(MODE_ENC, quad(25, 25, 0, 0), quad(0, 0, 0, 0)));
        // codes above 25 fold back; unused fields are ignored
        pending_words.push_back(mk(MODE_ENC, quad(31, 26, 31, 31), quad(31, 31, 31, 31)));
        pending_words.push_back(mk(MODE_DEC, quad(25, 0, 17, 9), quad(3, 22, 31, 1)));
        pending_words.push_back(mk(MODE_DEC, quad(30, 13, 0, 0), quad(0, 0, 0, 0)));
        pending_words.push_back(mk(MODE_KEY, quad(1, 0, 0, 1), quad(25, 25, 25, 25)));
        pending_words.push_back(mk(MODE_KEY, quad(25, 0, 0, 1), quad(0, 25, 25, 0)));
        // plaintext blocks with no inverse, then some that can be inverted, then undefined modes
        pending_words.push_back(mk(MODE_KEY, quad(0, 0, 0, 0), quad(5, 6, 7, 8)));
        pending_words.push_back(mk(MODE_KEY, quad(13, 0, 0, 1), quad(1, 2, 3, 4)));
        pending_words.push_back(mk(MODE_KEY, quad(2, 0, 0, 1), quad(9, 9, 9, 9)));
        pending_words.push_back(mk(MODE_KEY, quad(31, 31, 31, 31), quad(1, 1, 1, 1)));
        pending_words.push_back(mk(MODE_KEY, quad(27, 31, 26, 29), quad(31, 30, 28, 26)));
        pending_words.push_back(mk(MODE_KEY, quad(7, 4, 11, 15), quad(7, 8, 0, 11)));
        pending_words.push_back(mk(MODE_KEY, quad(25, 25, 24, 25), quad(25, 25, 25, 25)));
        pending_words.push_back(mk(MODE_UNDEF, quad(0, 0, 0, 0), quad(0, 0, 0, 0)));
        pending_words.push_back(mk(MODE_UNDEF, quad(31, 31, 31, 31), quad(31, 31, 31, 31)));
        settle();

        // random words under a series of keys
        for (ph = 0; ph < KEY_PHASES; ph++) begin
            load_key(key_plan[ph]);
            gaps_on = (ph % 3 != 2);
            for (n = 0; n < RAND_PER_KEY; n++) pending_words.push_back(rand_word());
            settle();
        end

        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/hc_pkg.sv
rtl/hc_mac.sv
rtl/hill_cipher_2x2_mod26.sv
tb/tb_hill_cipher_2x2_mod26.sv
